// ===== rtl/core/affine_span_texel_blender_defines.svh =====
// Assertion helpers shared by the blender RTL.
`ifndef AFFINE_SPAN_TEXEL_BLENDER_DEFINES_SVH
`define AFFINE_SPAN_TEXEL_BLENDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASTB_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASTB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("next-cycle property violated");

`endif

// ===== rtl/core/astb_pkg.sv =====
package astb_pkg;

  typedef enum logic [2:0] {
    KIND_TEXEL  = 3'd0,
    KIND_LIGHT  = 3'd1,
    KIND_FG     = 3'd2,
    KIND_BG     = 3'd3,
    KIND_COLOUR = 3'd4,
    KIND_MASK   = 3'd5,
    KIND_SPAN   = 3'd6,
    KIND_PIXEL  = 3'd7
  } kind_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_U_SHIFT    = 3'd0;
  localparam logic [2:0] CFG_V_SHIFT    = 3'd1;
  localparam logic [2:0] CFG_U_MASK     = 3'd2;
  localparam logic [2:0] CFG_BLEND_MODE = 3'd3;
  localparam logic [2:0] CFG_USE_ALPHA  = 3'd4;

  localparam logic [1:0] BLEND_SOLID = 2'd0;
  localparam logic [1:0] BLEND_TRANS = 2'd1;
  localparam logic [1:0] BLEND_ADD   = 2'd2;

  localparam logic [4:0]  RST_U_SHIFT = 5'd20;
  localparam logic [4:0]  RST_V_SHIFT = 5'd26;
  localparam logic [31:0] RST_U_MASK  = 32'h0000_0FC0;

  // Packed-channel arithmetic constants for the blend word.
  localparam logic [31:0] CH_GUARD = 32'h01f0_7c1f;
  localparam logic [31:0] CH_CARRY = 32'h4010_0400;
  localparam logic [31:0] CH_KEEP  = 32'h3fff_ffff;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [4:0]  u_shift;
    logic [4:0]  v_shift;
    logic [31:0] u_mask;
    logic [1:0]  blend_mode;
    logic        use_alpha;
  } cfg_t;

  // One queued operation for the back pipeline.
  typedef struct packed {
    kind_t       kind;
    logic [14:0] idx;
    logic [31:0] val;
    logic [7:0]  bgpix;
  } op_t;

endpackage

// ===== rtl/core/affine_span_texel_blender.sv =====
// Affine span texel blender: draws a textured span one pixel per beat. Input beats
// either load a table entry, start a span (positions and steps) or carry a pixel;
// only pixel beats produce an output beat, in order. The block accepts one beat per
// clock cycle whenever the output side keeps up; a pixel's result is built in a pipeline
// with one registered stage each for the texture read, the light map, the foreground
// table, the blend, the colour table and the output register, since each table read
// depends on the one before it.
// A four-entry queue separates the position front end from that pipeline. Tables come
// up undefined and must be loaded before use; there is no clearing pass after reset.
// Configuration must be written only while the block is idle; the block does not enforce it.
module affine_span_texel_blender #(
  parameter int TEXTURE_INDEX_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [14:0] table_index, [46:15] table_value, [78:47] u_start, [110:79] v_start,
  // [142:111] u_increment, [174:143] v_increment, [182:175] background_pixel, [183] zero
  input  logic [183:0] in_tdata,
  // [2:0] kind
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] pixel_value
  output logic [7:0]   out_tdata,
  // [0] write_enable
  output logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import astb_pkg::*;

  cfg_t                          cfg_r;
  logic                          q_full, q_push, q_valid, q_pop;
  op_t                           push_op, head_op;
  logic [TEXTURE_INDEX_BITS-1:0] push_taddr, head_taddr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.u_shift    <= RST_U_SHIFT;
      cfg_r.v_shift    <= RST_V_SHIFT;
      cfg_r.u_mask     <= RST_U_MASK;
      cfg_r.blend_mode <= BLEND_SOLID;
      cfg_r.use_alpha  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_U_SHIFT:    cfg_r.u_shift    <= cfg_data[4:0];
        CFG_V_SHIFT:    cfg_r.v_shift    <= cfg_data[4:0];
        CFG_U_MASK:     cfg_r.u_mask     <= cfg_data;
        CFG_BLEND_MODE: cfg_r.blend_mode <= cfg_data[1:0];
        CFG_USE_ALPHA:  cfg_r.use_alpha  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  astb_front #(.TEX_BITS(TEXTURE_INDEX_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .in_idx     (in_tdata[14:0]),
    .in_val     (in_tdata[46:15]),
    .in_u_start (in_tdata[78:47]),
    .in_v_start (in_tdata[110:79]),
    .in_u_inc   (in_tdata[142:111]),
    .in_v_inc   (in_tdata[174:143]),
    .in_bgpix   (in_tdata[182:175]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_op       (push_op),
    .q_taddr    (push_taddr)
  );

  astb_queue #(.TEX_BITS(TEXTURE_INDEX_BITS)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (push_op),
    .push_taddr (push_taddr),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head_op    (head_op),
    .head_taddr (head_taddr)
  );

  astb_back #(.TEX_BITS(TEXTURE_INDEX_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_op       (head_op),
    .q_taddr    (head_taddr),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_pix    (out_tdata),
    .out_we     (out_tuser[0])
  );

endmodule

// ===== rtl/core/astb_queue.sv =====
module astb_queue #(
  parameter int TEX_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  astb_pkg::op_t        push_op,
  input  logic [TEX_BITS-1:0]  push_taddr,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output astb_pkg::op_t        head_op,
  output logic [TEX_BITS-1:0]  head_taddr
);
  import astb_pkg::*;
  `include "affine_span_texel_blender_defines.svh"

  op_t                 op_q   [QUEUE_DEPTH];
  logic [TEX_BITS-1:0] addr_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid      = (count_r != '0);
  assign head_op    = op_q[rd_ptr_r];
  assign head_taddr = addr_q[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wr_ptr_r]   <= push_op;
      addr_q[wr_ptr_r] <= push_taddr;
    end
  end

  `ASTB_ASSERT_IMPLIES(a_no_push_when_full, clk, rst_n, full, !push)
  `ASTB_ASSERT_IMPLIES(a_no_pop_when_empty, clk, rst_n, !valid, !pop)

endmodule

// ===== rtl/core/astb_front.sv =====
module astb_front #(
  parameter int TEX_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  astb_pkg::cfg_t       cfg,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2:0]           in_kind,
  input  logic [14:0]          in_idx,
  input  logic [31:0]          in_val,
  input  logic [31:0]          in_u_start,
  input  logic [31:0]          in_v_start,
  input  logic [31:0]          in_u_inc,
  input  logic [31:0]          in_v_inc,
  input  logic [7:0]           in_bgpix,
  input  logic                 q_full,
  output logic                 q_push,
  output astb_pkg::op_t        q_op,
  output logic [TEX_BITS-1:0]  q_taddr
);
  import astb_pkg::*;

  logic [31:0]          u_pos_r, v_pos_r, u_step_r, v_step_r;
  logic                 accept;
  kind_t                kind;
  logic [31:0]          texel_full;
  logic [TEX_BITS+14:0] idx_ext;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign kind      = kind_t'(in_kind);

  // Texel address from the current positions; loads use their own index instead.
  assign texel_full = ((u_pos_r >> cfg.u_shift) & cfg.u_mask) | (v_pos_r >> cfg.v_shift);
  assign idx_ext    = {{TEX_BITS{1'b0}}, in_idx};

  always_comb begin
    q_push      = accept && (kind != KIND_SPAN);
    q_op.kind   = kind;
    q_op.idx    = in_idx;
    q_op.val    = in_val;
    q_op.bgpix  = in_bgpix;
    if (kind == KIND_PIXEL) begin
      q_taddr = texel_full[TEX_BITS-1:0];
    end else begin
      q_taddr = idx_ext[TEX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_pos_r  <= '0;
      v_pos_r  <= '0;
      u_step_r <= '0;
      v_step_r <= '0;
    end else if (accept) begin
      if (kind == KIND_SPAN) begin
        u_pos_r  <= in_u_start;
        v_pos_r  <= in_v_start;
        u_step_r <= in_u_inc;
        v_step_r <= in_v_inc;
      end else if (kind == KIND_PIXEL) begin
        u_pos_r <= u_pos_r + u_step_r;
        v_pos_r <= v_pos_r + v_step_r;
      end
    end
  end

endmodule

// ===== rtl/core/astb_back.sv =====
module astb_back #(
  parameter int TEX_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  astb_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  input  astb_pkg::op_t        q_op,
  input  logic [TEX_BITS-1:0]  q_taddr,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_pix,
  output logic                 out_we
);
  import astb_pkg::*;
  `include "affine_span_texel_blender_defines.svh"

  localparam int TEX_DEPTH = 1 << TEX_BITS;

  logic [7:0]  tex_mem    [TEX_DEPTH];
  logic        mask_mem   [TEX_DEPTH];
  logic [7:0]  light_mem  [256];
  logic [31:0] bg_mem     [256];
  logic [31:0] fg_mem     [256];
  logic [7:0]  colour_mem [32768];

  logic        adv;
  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  op_t         op1_r, op2_r, op3_r, op4_r, op5_r;
  logic [7:0]  tex_rd_r, light_rd_r, colour_rd_r;
  logic        mask_rd_r, mask2_r, mask3_r, mask4_r, mask5_r;
  logic [31:0] bg_rd_r, fg_rd_r, bg3_r;
  logic [7:0]  lit3_r, lit4_r, lit5_r;
  logic [14:0] cidx4_r;
  logic        out_valid_r, out_we_r;
  logic [7:0]  out_pix_r;

  logic [31:0] sum, carry, keep, sat, blend_w;
  logic [14:0] cidx_nxt;
  logic [7:0]  pix_nxt;
  logic        we_nxt;

  // Whole pipeline moves together; it only holds while a result waits.
  assign adv        = !out_valid_r || out_tready;
  assign q_pop      = adv && q_valid;
  assign out_tvalid = out_valid_r;
  assign out_pix    = out_pix_r;
  assign out_we     = out_we_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      out_valid_r <= v5_r && (op5_r.kind == KIND_PIXEL);
    end
  end

  // Each table is touched at one stage only, so loads and lookups keep stream order.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (q_valid && q_op.kind == KIND_TEXEL) begin
        tex_mem[q_taddr] <= q_op.val[7:0];
      end
      if (q_valid && q_op.kind == KIND_MASK) begin
        mask_mem[q_taddr] <= q_op.val[0];
      end
      tex_rd_r  <= tex_mem[q_taddr];
      mask_rd_r <= mask_mem[q_taddr];
      op1_r     <= q_op;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (v1_r && op1_r.kind == KIND_LIGHT) begin
        light_mem[op1_r.idx[7:0]] <= op1_r.val[7:0];
      end
      if (v1_r && op1_r.kind == KIND_BG) begin
        bg_mem[op1_r.idx[7:0]] <= op1_r.val;
      end
      light_rd_r <= light_mem[tex_rd_r];
      bg_rd_r    <= bg_mem[op1_r.bgpix];
      op2_r      <= op1_r;
      mask2_r    <= mask_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (v2_r && op2_r.kind == KIND_FG) begin
        fg_mem[op2_r.idx[7:0]] <= op2_r.val;
      end
      fg_rd_r <= fg_mem[light_rd_r];
      lit3_r  <= light_rd_r;
      bg3_r   <= bg_rd_r;
      op3_r   <= op2_r;
      mask3_r <= mask2_r;
    end
  end

  // Three channels packed with guard bits; the additive mode turns each
  // channel's carry into an all-ones field for saturation.
  always_comb begin
    sum   = bg3_r + fg_rd_r;
    carry = sum & CH_CARRY;
    keep  = (sum | CH_GUARD) & CH_KEEP;
    sat   = carry - (carry >> 5);
    if (cfg.blend_mode == BLEND_ADD) begin
      blend_w = keep | sat;
    end else begin
      blend_w = sum | CH_GUARD;
    end
    cidx_nxt = blend_w[14:0] & blend_w[29:15];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cidx4_r <= cidx_nxt;
      lit4_r  <= lit3_r;
      op4_r   <= op3_r;
      mask4_r <= mask3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (v4_r && op4_r.kind == KIND_COLOUR) begin
        colour_mem[op4_r.idx] <= op4_r.val[7:0];
      end
      colour_rd_r <= colour_mem[cidx4_r];
      lit5_r      <= lit4_r;
      op5_r       <= op4_r;
      mask5_r     <= mask4_r;
    end
  end

  always_comb begin
    if (cfg.use_alpha && !mask5_r) begin
      pix_nxt = op5_r.bgpix;
      we_nxt  = 1'b0;
    end else begin
      we_nxt = 1'b1;
      case (cfg.blend_mode)
        BLEND_TRANS: pix_nxt = colour_rd_r;
        BLEND_ADD:   pix_nxt = colour_rd_r;
        default:     pix_nxt = lit5_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r <= pix_nxt;
      out_we_r  <= we_nxt;
    end
  end

  `ASTB_ASSERT_NEXT(a_stall_holds_pipe, clk, rst_n, !adv,
    $stable({v1_r, v2_r, v3_r, v4_r, v5_r}))
  `ASTB_ASSERT_NEXT(a_result_only_from_pixel, clk, rst_n,
    adv && !(v5_r && op5_r.kind == KIND_PIXEL), !out_valid_r)
  `ASTB_ASSERT_NEXT(a_masked_keeps_dest, clk, rst_n,
    adv && v5_r && op5_r.kind == KIND_PIXEL && cfg.use_alpha && !mask5_r,
    out_valid_r && !out_we_r && out_pix_r == $past(op5_r.bgpix))

endmodule

// ===== tb/tb_affine_span_texel_blender.sv =====
`timescale 1ns / 1ps

module tb_affine_span_texel_blender;
  import astb_pkg::*;

  localparam int TEX_BITS      = 12;
  localparam int TEX_DEPTH     = 1 << TEX_BITS;
  localparam int CLUT_DEPTH    = 32768;
  localparam int DRAIN_CYCLES  = 24;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 88;
  localparam int LONG_HOLD     = 300;
  localparam logic [1:0] BLEND_SPARE = 2'd3;

  typedef enum int {
    TRAFFIC_FULL,
    TRAFFIC_TX_GAPS,
    TRAFFIC_RX_STALLS,
    TRAFFIC_BOTH
  } traffic_t;

  typedef struct {
    kind_t     kind;
    bit [14:0] idx;
    bit [31:0] val;
    bit [31:0] u0;
    bit [31:0] v0;
    bit [31:0] du;
    bit [31:0] dv;
    bit [7:0]  bgpix;
  } span_beat_t;

  typedef struct {
    bit [7:0] pix;
    bit       we;
  } pixel_res_t;

  typedef struct {
    bit         is_reg;
    bit [2:0]   reg_idx;
    bit [31:0]  reg_val;
    span_beat_t beat;
    bit         typed;
    pixel_res_t want;
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [183:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  // Shadow copy of the block's stores, span registers and configuration.
  bit [7:0]  tex_mem   [TEX_DEPTH];
  bit        amask_mem [TEX_DEPTH];
  bit [7:0]  light_mem [256];
  bit [31:0] fg_mem    [256];
  bit [31:0] bg_mem    [256];
  bit [7:0]  clut_mem  [CLUT_DEPTH];
  bit [31:0] u_pos  = '0;
  bit [31:0] v_pos  = '0;
  bit [31:0] u_step = '0;
  bit [31:0] v_step = '0;
  bit [4:0]  u_sh     = RST_U_SHIFT;
  bit [4:0]  v_sh     = RST_V_SHIFT;
  bit [31:0] u_msk    = RST_U_MASK;
  bit [1:0]  blend    = BLEND_SOLID;
  bit        alpha_on = 1'b0;

  // Marks of the store entries that have been loaded at least once.
  bit tex_set   [TEX_DEPTH];
  bit amask_set [TEX_DEPTH];
  bit light_set [256];
  bit fg_set    [256];
  bit bg_set    [256];
  bit clut_set  [CLUT_DEPTH];

  pixel_res_t pending_pixels[$];
  int         fail_count  = 0;
  int         beats_sent  = 0;
  traffic_t   traffic_mode = TRAFFIC_FULL;
  int         rx_hold_req  = 0;

  affine_span_texel_blender #(
    .TEXTURE_INDEX_BITS(TEX_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int tx_idle_pct();
    case (traffic_mode)
      TRAFFIC_TX_GAPS: return 73;
      TRAFFIC_BOTH:    return 28;
      default:         return 0;
    endcase
  endfunction

  function automatic int rx_stall_pct();
    case (traffic_mode)
      TRAFFIC_RX_STALLS: return 73;
      TRAFFIC_BOTH:      return 28;
      default:           return 0;
    endcase
  endfunction

  function automatic bit [7:0] clut_read(bit [31:0] w);
    bit [31:0] folded;
    folded = w & (w >> 15);
    return clut_mem[folded[14:0]];
  endfunction

  // Colour table entry that a blend sum selects in the current blend mode.
  function automatic bit [14:0] clut_index(bit [31:0] sum);
    bit [31:0] w;
    bit [31:0] carry;
    w = sum | CH_GUARD;
    if (blend == BLEND_ADD) begin
      carry = sum & CH_CARRY;
      carry = carry - (carry >> 5);
      w     = ((sum | CH_GUARD) & CH_KEEP) | carry;
    end
    w = w & (w >> 15);
    return w[14:0];
  endfunction

  // Texel fetch, alpha mask, light map and blend for the current span position.
  function automatic pixel_res_t shade_pixel(bit [7:0] bgpix);
    bit [31:0]  ti_full;
    bit [31:0]  sum;
    bit [31:0]  carry;
    bit [TEX_BITS-1:0] ti;
    bit [7:0]   lit;
    pixel_res_t res;
    ti_full = ((u_pos >> u_sh) & u_msk) | (v_pos >> v_sh);
    ti      = ti_full[TEX_BITS-1:0];
    lit     = light_mem[tex_mem[ti]];
    sum     = bg_mem[bgpix] + fg_mem[lit];
    if (alpha_on && !amask_mem[ti]) begin
      res.pix = bgpix;
      res.we  = 1'b0;
    end else begin
      res.we = 1'b1;
      case (blend)
        BLEND_TRANS: res.pix = clut_read(sum | CH_GUARD);
        BLEND_ADD: begin
          carry   = sum & CH_CARRY;
          carry   = carry - (carry >> 5);
          res.pix = clut_read(((sum | CH_GUARD) & CH_KEEP) | carry);
        end
        default: res.pix = lit;
      endcase
    end
    return res;
  endfunction

  function automatic void absorb_beat(span_beat_t b, output bit has_res,
                                      output pixel_res_t res);
    has_res = 1'b0;
    res     = '{8'h00, 1'b0};
    case (b.kind)
      KIND_TEXEL: begin
        tex_mem[b.idx[TEX_BITS-1:0]] = b.val[7:0];
        tex_set[b.idx[TEX_BITS-1:0]] = 1'b1;
      end
      KIND_LIGHT: begin
        light_mem[b.idx[7:0]] = b.val[7:0];
        light_set[b.idx[7:0]] = 1'b1;
      end
      KIND_FG: begin
        fg_mem[b.idx[7:0]] = b.val;
        fg_set[b.idx[7:0]] = 1'b1;
      end
      KIND_BG: begin
        bg_mem[b.idx[7:0]] = b.val;
        bg_set[b.idx[7:0]] = 1'b1;
      end
      KIND_COLOUR: begin
        clut_mem[b.idx] = b.val[7:0];
        clut_set[b.idx] = 1'b1;
      end
      KIND_MASK: begin
        amask_mem[b.idx[TEX_BITS-1:0]] = b.val[0];
        amask_set[b.idx[TEX_BITS-1:0]] = 1'b1;
      end
      KIND_SPAN: begin
        u_pos  = b.u0;
        v_pos  = b.v0;
        u_step = b.du;
        v_step = b.dv;
      end
      default: begin
        res     = shade_pixel(b.bgpix);
        has_res = 1'b1;
        u_pos   = u_pos + u_step;
        v_pos   = v_pos + v_step;
      end
    endcase
  endfunction

  function automatic span_beat_t make_beat(kind_t k);
    span_beat_t b;
    b.kind  = k;
    b.idx   = 15'($urandom_range(0, 32767));
    b.val   = $urandom;
    b.u0    = $urandom;
    b.v0    = $urandom;
    b.du    = roll(50) ? $urandom : $urandom_range(0, 32'h0040_0000);
    b.dv    = roll(50) ? $urandom : $urandom_range(0, 32'h0040_0000);
    b.bgpix = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic stim_row_t load_row(kind_t k, bit [14:0] i, bit [31:0] v);
    stim_row_t r;
    r.beat   = make_beat(k);
    r.beat.idx = i;
    r.beat.val = v;
    return r;
  endfunction

  function automatic stim_row_t span_row(bit [31:0] u, bit [31:0] v,
                                         bit [31:0] du, bit [31:0] dv);
    stim_row_t r;
    r = load_row(KIND_SPAN, 15'h0, 32'h0);
    r.beat.u0 = u;
    r.beat.v0 = v;
    r.beat.du = du;
    r.beat.dv = dv;
    return r;
  endfunction

  function automatic stim_row_t pix_row(bit [7:0] bg, bit typed, bit [7:0] pix, bit we);
    stim_row_t r;
    r = load_row(KIND_PIXEL, 15'h0, 32'h0);
    r.beat.bgpix = bg;
    r.typed      = typed;
    r.want       = '{pix, we};
    return r;
  endfunction

  function automatic stim_row_t reg_row(bit [2:0] idx, bit [31:0] val);
    stim_row_t r;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Entered and left at a falling edge; the beat is absorbed when it is taken.
  // A pixel is preceded by loads of any entry it reads that was never written.
  task automatic send_beat(input span_beat_t b, input bit typed, input pixel_res_t want);
    bit         has_res;
    pixel_res_t res;
    if (b.kind == KIND_PIXEL) fill_for_pixel(b.bgpix);
    while (roll(tx_idle_pct())) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= b.kind;
    in_tdata  <= {1'b0, b.bgpix, b.dv, b.du, b.v0, b.u0, b.val, b.idx};
    do @(posedge clk); while (!in_tready);
    absorb_beat(b, has_res, res);
    beats_sent++;
    if (has_res) pending_pixels.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  task automatic send_random(input span_beat_t b);
    send_beat(b, 1'b0, '{8'h00, 1'b0});
  endtask

  // Random load of one entry; the bits above the store size stay random.
  task automatic send_fill(input kind_t k, input bit [14:0] i, input bit [14:0] cut);
    span_beat_t b;
    b     = make_beat(k);
    b.idx = (b.idx & ~cut) | i;
    send_random(b);
  endtask

  task automatic fill_for_pixel(input bit [7:0] bgpix);
    bit [31:0]         ti_full;
    bit [TEX_BITS-1:0] ti;
    bit [7:0]          lit;
    bit [14:0]         cidx;
    ti_full = ((u_pos >> u_sh) & u_msk) | (v_pos >> v_sh);
    ti      = ti_full[TEX_BITS-1:0];
    if (!tex_set[ti])   send_fill(KIND_TEXEL, 15'(ti), 15'(TEX_DEPTH - 1));
    if (!amask_set[ti]) send_fill(KIND_MASK, 15'(ti), 15'(TEX_DEPTH - 1));
    if (!light_set[tex_mem[ti]]) send_fill(KIND_LIGHT, 15'(tex_mem[ti]), 15'h00FF);
    lit = light_mem[tex_mem[ti]];
    if (!bg_set[bgpix]) send_fill(KIND_BG, 15'(bgpix), 15'h00FF);
    if (!fg_set[lit])   send_fill(KIND_FG, 15'(lit), 15'h00FF);
    if (blend == BLEND_TRANS || blend == BLEND_ADD) begin
      cidx = clut_index(bg_mem[bgpix] + fg_mem[lit]);
      if (!clut_set[cidx]) send_fill(KIND_COLOUR, cidx, 15'h7FFF);
    end
  endtask

  // Stops offering beats until every pixel has come back, then lets the pipe empty.
  task automatic settle_block(input int extra);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input bit [2:0] idx, input bit [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_U_SHIFT:    u_sh     = val[4:0];
      CFG_V_SHIFT:    v_sh     = val[4:0];
      CFG_U_MASK:     u_msk    = val;
      CFG_BLEND_MODE: blend    = val[1:0];
      CFG_USE_ALPHA:  alpha_on = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_regs(input bit [4:0] us, input bit [4:0] vs, input bit [31:0] um,
                              input bit [1:0] bm, input bit am);
    settle_block(DRAIN_CYCLES);
    write_reg(CFG_U_SHIFT, {27'h0, us});
    write_reg(CFG_V_SHIFT, {27'h0, vs});
    write_reg(CFG_U_MASK, um);
    write_reg(CFG_BLEND_MODE, {30'h0, bm});
    write_reg(CFG_USE_ALPHA, {31'h0, am});
    cfg_valid <= 1'b0;
  endtask

  // Spans followed by runs of pixels, with table loads mixed in and some stray runs.
  task automatic run_spans(input int n_items, input bit pause_midway);
    int  first;
    int  run_len;
    bit  paused;
    first  = beats_sent;
    paused = 1'b0;
    while (beats_sent - first < n_items) begin
      if (pause_midway && !paused && beats_sent - first >= n_items / 2) begin
        settle_block(0);
        paused = 1'b1;
      end
      if (roll(85)) begin
        send_random(make_beat(KIND_SPAN));
        run_len = $urandom_range(1, 20);
      end else begin
        run_len = $urandom_range(1, 4);
      end
      repeat (run_len) begin
        if (beats_sent - first < n_items) begin
          if (roll(80)) send_random(make_beat(KIND_PIXEL));
          else          send_random(make_beat(kind_t'($urandom_range(0, 5))));
        end
      end
    end
  endtask

  initial begin : drive_ready
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !roll(rx_stall_pct());
      end
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected pixel beat value=%02h we=%0b",
                   $realtime, out_tdata, out_tuser[0]);
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata !== want.pix || out_tuser[0] !== want.we) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: pixel mismatch expected value=%02h we=%0b got value=%02h we=%0b",
                     $realtime, want.pix, want.we, out_tdata, out_tuser[0]);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t rows[$];
    traffic_t  mode;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_TEXEL;
    cfg_valid = 1'b0;
    cfg_index = CFG_U_SHIFT;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset positions and configuration: texel 0 then light map.
    rows.push_back(load_row(KIND_TEXEL, 15'h0000, 32'h0000_005A));
    rows.push_back(load_row(KIND_LIGHT, 15'h005A, 32'h0000_00C3));
    rows.push_back(pix_row(8'h00, 1'b1, 8'hC3, 1'b1));
    // Top table indexes are cut to the store size; all-ones positions hit texel 4095.
    rows.push_back(load_row(KIND_TEXEL, 15'h7FFF, 32'hFFFF_FF11));
    rows.push_back(load_row(KIND_LIGHT, 15'h7F11, 32'hFFFF_FF22));
    rows.push_back(span_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
    rows.push_back(pix_row(8'hFF, 1'b1, 8'h22, 1'b1));
    rows.push_back(load_row(KIND_MASK, 15'h7FFF, 32'hFFFF_FFFE));
    rows.push_back(reg_row(CFG_USE_ALPHA, 32'h1));
    rows.push_back(pix_row(8'hA5, 1'b1, 8'hA5, 1'b0));
    rows.push_back(load_row(KIND_MASK, 15'h0FFF, 32'h0000_0001));
    rows.push_back(pix_row(8'hA5, 1'b1, 8'h22, 1'b1));
    rows.push_back(reg_row(CFG_BLEND_MODE, {30'h0, BLEND_TRANS}));
    rows.push_back(load_row(KIND_FG, 15'h7F22, 32'hFFFF_FFFF));
    rows.push_back(load_row(KIND_BG, 15'h00FF, 32'hFFFF_FFFF));
    rows.push_back(load_row(KIND_COLOUR, 15'h7FFF, 32'h0000_00EE));
    rows.push_back(pix_row(8'hFF, 1'b0, 8'h00, 1'b0));
    rows.push_back(reg_row(CFG_BLEND_MODE, {30'h0, BLEND_ADD}));
    rows.push_back(pix_row(8'hFF, 1'b0, 8'h00, 1'b0));
    rows.push_back(load_row(KIND_FG, 15'h0000, 32'h0000_0000));
    rows.push_back(load_row(KIND_BG, 15'h0000, 32'h0000_0000));
    rows.push_back(pix_row(8'h00, 1'b0, 8'h00, 1'b0));
    // Steps of all ones and the top bit make both positions wrap.
    rows.push_back(span_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000));
    rows.push_back(reg_row(CFG_BLEND_MODE, {30'h0, BLEND_SPARE}));
    rows.push_back(pix_row(8'h5A, 1'b0, 8'h00, 1'b0));
    rows.push_back(pix_row(8'hC3, 1'b0, 8'h00, 1'b0));
    rows.push_back(pix_row(8'h3C, 1'b0, 8'h00, 1'b0));

    traffic_mode = TRAFFIC_BOTH;
    foreach (rows[i]) begin
      if (rows[i].is_reg) begin
        settle_block(DRAIN_CYCLES);
        write_reg(rows[i].reg_idx, rows[i].reg_val);
        cfg_valid <= 1'b0;
      end else begin
        send_beat(rows[i].beat, rows[i].typed, rows[i].want);
      end
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: program_regs(5'd0, 5'd0, 32'h0000_0000, BLEND_SOLID, 1'b0);
        1: program_regs(5'd31, 5'd31, 32'hFFFF_FFFF, BLEND_ADD, 1'b1);
        2: program_regs(RST_U_SHIFT, RST_V_SHIFT, RST_U_MASK, BLEND_TRANS, 1'b1);
        default: program_regs(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                              $urandom, 2'($urandom_range(0, 3)),
                              1'($urandom_range(0, 1)));
      endcase
      mode         = traffic_t'(p % 4);
      traffic_mode = mode;
      // A long output stall while the sender keeps pushing backs up the whole pipe.
      if (p == 4) rx_hold_req = LONG_HOLD;
      run_spans(PHASE_ITEMS, p == 6);
    end

    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/astb_pkg.sv
rtl/core/astb_queue.sv
rtl/core/astb_front.sv
rtl/core/astb_back.sv
rtl/core/affine_span_texel_blender.sv
tb/tb_affine_span_texel_blender.sv
